FILE: rtl/hsd_pkg.sv
// ---------------------------------------------------------------------------
// hsd_pkg: shared types and tables for the Hall sector decoder
// Holds the Hall code and step tables, register indexes and the struct
// that carries one decoded sample from the decode logic to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF  = 15;
    localparam int COUNT_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd1;

    // Field widths
    localparam int CODE_W  = 3;
    localparam int SECT_W  = 3;
    localparam int STEP_W  = 3;
    localparam int ANGLE_W = 17;
    localparam int TOTAL_W = 32;
    localparam int CNT_W   = 32;

    // Invalid Hall patterns
    localparam logic [CODE_W-1:0] CODE_ALL_LOW  = 3'b000;
    localparam logic [CODE_W-1:0] CODE_ALL_HIGH = 3'b111;

    // The step of half a turn cannot tell its direction
    localparam logic signed [STEP_W-1:0] STEP_AMBIG = 3'sd3;
    localparam logic signed [STEP_W-1:0] STEP_ZERO  = 3'sd0;

    typedef logic [CODE_W-1:0]         code_t;
    typedef logic [SECT_W-1:0]         sector_t;
    typedef logic signed [STEP_W-1:0]  step_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // One decoded sample
    typedef struct packed {
        logic    changed;    // sample differs from last accepted code
        logic    fault;      // changed and invalid
        logic    load;       // changed and valid: update sector state
        sector_t sector;     // sector of the sample
        step_t   step;       // signed step after direction handling
        logic    plain_we;   // step was unambiguous
        step_t   plain_step; // step before direction handling and inversion
        angle_t  raw_angle;  // sector angle, sign follows inversion
        angle_t  angle;      // raw angle plus offset
    } dec_t;

    // Hall pattern (B C A) to electrical sector
    function automatic sector_t code_to_sector(input code_t code);
        sector_t s;
        case (code)
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd1;
            3'd4:    s = 3'd4;
            3'd5:    s = 3'd5;
            3'd6:    s = 3'd3;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Sector difference modulo six to signed step
    function automatic step_t diff_to_step(input sector_t d);
        step_t s;
        case (d)
            3'd1:    s = 3'sd1;
            3'd2:    s = 3'sd2;
            3'd3:    s = 3'sd3;
            3'd4:    s = -3'sd2;
            3'd5:    s = -3'sd1;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hsd_if.sv
// ---------------------------------------------------------------------------
// hsd_if: channel interfaces of the Hall sector decoder
// Sample input, result output and configuration write channels, each a
// valid/ready handshake with its payload.
// ---------------------------------------------------------------------------
`default_nettype none

interface hsd_in_if;
    logic            valid;
    logic            ready;
    hsd_pkg::code_t  hall_code;

    modport source (output valid, output hall_code, input ready);
    modport sink   (input valid, input hall_code, output ready);
endinterface

interface hsd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          code_changed;
    logic                          fault;
    hsd_pkg::sector_t              sector;
    hsd_pkg::step_t                step;
    hsd_pkg::angle_t               angle;
    hsd_pkg::angle_t               raw_angle;
    logic signed [hsd_pkg::TOTAL_W-1:0] step_total;
    logic [hsd_pkg::CNT_W-1:0]     transitions_seen;
    logic [hsd_pkg::CNT_W-1:0]     faults_seen;

    modport source (output valid, output code_changed, output fault, output sector,
                    output step, output angle, output raw_angle, output step_total,
                    output transitions_seen, output faults_seen, input ready);
    modport sink   (input valid, input code_changed, input fault, input sector,
                    input step, input angle, input raw_angle, input step_total,
                    input transitions_seen, input faults_seen, output ready);
endinterface

interface hsd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hsd_pkg::CFG_IDX_W-1:0]    idx;
    logic [hsd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hsd_decode.sv
// ---------------------------------------------------------------------------
// hsd_decode: per-sample decode logic
// Compares a sample with the last accepted code, maps it to a sector,
// derives the signed step and the sector angle with inversion and offset.
// ---------------------------------------------------------------------------
`default_nettype none

module hsd_decode #(
    parameter int FRAC_BITS = hsd_pkg::FRAC_BITS_DEF
) (
    input  wire hsd_pkg::code_t             code,
    input  wire hsd_pkg::code_t             last_code,
    input  wire logic                       code_known,
    input  wire hsd_pkg::sector_t           prev_sector,
    input  wire logic                       sector_known,
    input  wire hsd_pkg::step_t             last_plain,
    input  wire logic                       invert,
    input  wire logic signed [hsd_pkg::CFG_DATA_W-1:0] offset,
    output hsd_pkg::dec_t                   dec
);

    // Angle arithmetic is wide enough for a half turn and for the output
    localparam int ANG_W = (FRAC_BITS + 2 > hsd_pkg::ANGLE_W) ?
                           FRAC_BITS + 2 : hsd_pkg::ANGLE_W;
    localparam logic signed [ANG_W-1:0] ANG_ONE =
        ANG_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ANG_W-1:0] ANG_THIRD =
        ANG_W'((64'd1 << FRAC_BITS) / 3);
    localparam logic signed [ANG_W-1:0] ANG_TWO_THIRDS =
        ANG_W'((64'd2 << FRAC_BITS) / 3);

    logic                      invalid;
    hsd_pkg::sector_t          sec;
    logic signed [3:0]         diff;
    hsd_pkg::sector_t          diff_mod;
    hsd_pkg::step_t            step_plain;
    logic                      ambig;
    hsd_pkg::step_t            step_dir;
    hsd_pkg::step_t            step_inv;
    logic signed [ANG_W-1:0]   raw_sec;
    logic signed [ANG_W-1:0]   raw_dir;
    logic signed [ANG_W-1:0]   angle_sum;

    always_comb
    begin
        // Classify the sample
        invalid = (code == hsd_pkg::CODE_ALL_LOW) || (code == hsd_pkg::CODE_ALL_HIGH);
        dec.changed = !code_known || (code != last_code);
        dec.fault   = dec.changed && invalid;
        dec.load    = dec.changed && !invalid;

        // Sector and step, with the half-turn step resolved by the last direction
        sec  = hsd_pkg::code_to_sector(code);
        diff = $signed({1'b0, sec}) - $signed({1'b0, prev_sector});
        diff_mod = diff[3] ? 3'(diff + 4'sd6) : diff[2:0];
        step_plain = sector_known ? hsd_pkg::diff_to_step(diff_mod) : hsd_pkg::STEP_ZERO;
        ambig = (step_plain == hsd_pkg::STEP_AMBIG);
        step_dir = (ambig && last_plain[2]) ? -hsd_pkg::STEP_AMBIG : step_plain;
        step_inv = invert ? -step_dir : step_dir;

        dec.sector     = sec;
        dec.step       = dec.load ? step_inv : hsd_pkg::STEP_ZERO;
        dec.plain_we   = dec.load && !ambig;
        dec.plain_step = step_plain;

        // Sector angle, inversion and offset
        case (sec)
            3'd1:    raw_sec = ANG_THIRD;
            3'd2:    raw_sec = ANG_TWO_THIRDS;
            3'd3:    raw_sec = ANG_ONE;
            3'd4:    raw_sec = -ANG_TWO_THIRDS;
            3'd5:    raw_sec = -ANG_THIRD;
            default: raw_sec = '0;
        endcase
        raw_dir   = invert ? -raw_sec : raw_sec;
        angle_sum = raw_dir + ANG_W'(offset);

        dec.raw_angle = raw_dir[hsd_pkg::ANGLE_W-1:0];
        dec.angle     = angle_sum[hsd_pkg::ANGLE_W-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/hall_sector_decoder.sv
// ---------------------------------------------------------------------------
// hall_sector_decoder: Hall sensor sector decoder
// Decodes 3-bit Hall samples into sector, step, angle and running counts.
// ---------------------------------------------------------------------------
// Takes one Hall sample per clock and returns one result per sample through
// the input register, then the result register. Samples may arrive back to
// back; the rate is one per clock, set by the single decode stage between
// the input register and the sector state, which updates together with the
// result register. A stalled result holds the input register, and the input
// side keeps taking samples as long as the result register is free or
// being drained. The configuration channel is always ready; write it only
// while no sample is in flight. Reset clears the configuration, sector
// state and counters: no code or sector known, counts zero.
// ---------------------------------------------------------------------------
`default_nettype none

module hall_sector_decoder #(
    parameter int FRAC_BITS  = hsd_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = hsd_pkg::COUNT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hsd_in_if.sink        sample,
    hsd_out_if.source     result,
    hsd_cfg_if.sink       cfg
);

    logic                                 invert_reg;
    logic signed [hsd_pkg::CFG_DATA_W-1:0] offset_reg;

    logic                 in_valid_reg;
    hsd_pkg::code_t       in_code_reg;

    hsd_pkg::code_t       last_code_reg;
    logic                 code_known_reg;
    hsd_pkg::sector_t     prev_sector_reg;
    logic                 sector_known_reg;
    hsd_pkg::step_t       last_plain_reg;
    logic signed [hsd_pkg::TOTAL_W-1:0] step_sum_reg;
    logic [COUNT_BITS-1:0] trans_cnt_reg;
    logic [COUNT_BITS-1:0] fault_cnt_reg;
    hsd_pkg::angle_t      held_angle_reg;
    hsd_pkg::angle_t      held_raw_reg;

    logic                 out_valid_reg;
    logic                 out_changed_reg;
    logic                 out_fault_reg;
    hsd_pkg::step_t       out_step_reg;

    hsd_pkg::dec_t        dec;
    logic                 advance;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.idx)
                hsd_pkg::CFG_INVERT: invert_reg <= cfg.data[0];
                hsd_pkg::CFG_OFFSET: offset_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Advance when a sample waits and the result register is free or drains
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_code_reg <= sample.hall_code;
        end
    end

    // Decode against the current state
    hsd_decode #(
        .FRAC_BITS (FRAC_BITS)
    ) u_decode (
        .code         (in_code_reg),
        .last_code    (last_code_reg),
        .code_known   (code_known_reg),
        .prev_sector  (prev_sector_reg),
        .sector_known (sector_known_reg),
        .last_plain   (last_plain_reg),
        .invert       (invert_reg),
        .offset       (offset_reg),
        .dec          (dec)
    );

    // Sector state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg    <= '0;
            code_known_reg   <= 1'b0;
            prev_sector_reg  <= '0;
            sector_known_reg <= 1'b0;
            last_plain_reg   <= '0;
            step_sum_reg     <= '0;
            trans_cnt_reg    <= '0;
            fault_cnt_reg    <= '0;
            held_angle_reg   <= '0;
            held_raw_reg     <= '0;
        end
        else if (advance)
        begin
            if (dec.changed)
            begin
                trans_cnt_reg <= trans_cnt_reg + 1'b1;
            end
            if (dec.fault)
            begin
                fault_cnt_reg <= fault_cnt_reg + 1'b1;
                step_sum_reg  <= '0;
            end
            if (dec.load)
            begin
                last_code_reg    <= in_code_reg;
                code_known_reg   <= 1'b1;
                prev_sector_reg  <= dec.sector;
                sector_known_reg <= 1'b1;
                held_angle_reg   <= dec.angle;
                held_raw_reg     <= dec.raw_angle;
                step_sum_reg     <= step_sum_reg
                                    + {{(hsd_pkg::TOTAL_W - hsd_pkg::STEP_W){dec.step[2]}},
                                       dec.step};
            end
            if (dec.plain_we)
            begin
                last_plain_reg <= dec.plain_step;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_changed_reg <= dec.changed;
            out_fault_reg   <= dec.fault;
            out_step_reg    <= dec.step;
        end
    end

    // Held state doubles as the result payload
    assign result.valid            = out_valid_reg;
    assign result.code_changed     = out_changed_reg;
    assign result.fault            = out_fault_reg;
    assign result.step             = out_step_reg;
    assign result.sector           = prev_sector_reg;
    assign result.angle            = held_angle_reg;
    assign result.raw_angle        = held_raw_reg;
    assign result.step_total       = step_sum_reg;
    assign result.transitions_seen = hsd_pkg::CNT_W'(trans_cnt_reg);
    assign result.faults_seen      = hsd_pkg::CNT_W'(fault_cnt_reg);

endmodule

`default_nettype wire
